[design/tga_rle_pkg.sv]
// ============================================================================
// tga_rle_pkg
// Types and codes shared by the truecolor TGA run decoder modules.
// ============================================================================
`default_nettype none

package tga_rle_pkg;

  // result kinds
  localparam logic [1:0] KIND_RUN    = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // report status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd4;
  localparam logic [2:0] ST_NO_PIXELS = 3'd5;
  localparam logic [2:0] ST_RAW_TRUNC = 3'd6;

  // default depth of the record queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // one input transaction
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } tga_rle_in_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [31:0] start_index;
    logic        top_origin;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } tga_rle_out_t;

  // work record for one byte: an optional run and an optional end report
  typedef struct packed {
    logic        has_run;
    logic        has_rep;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_len;
    logic [31:0] run_start;
    logic [2:0]  rep_status;
    logic [31:0] rep_start;
    logic        top_origin;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } tga_rle_rec_t;

endpackage

`default_nettype wire

[design/tga_rle_front.sv]
// ============================================================================
// tga_rle_front
// Byte parser: header fields, ID skip, raw and RLE pixel gathering; builds
// one work record per byte that yields a run and/or an end report.
// ============================================================================
`default_nettype none

module tga_rle_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tga_rle_pkg::tga_rle_in_t in_data,
  input  wire logic                     accept,
  output tga_rle_pkg::tga_rle_rec_t     rec,
  output logic                          push
);
  import tga_rle_pkg::*;

  // parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_IDSKIP = 3'd1;
  localparam logic [2:0] PH_RAWPIX = 3'd2;
  localparam logic [2:0] PH_RLEHDR = 3'd3;
  localparam logic [2:0] PH_RLEPIX = 3'd4;
  localparam logic [2:0] PH_DRAIN  = 3'd5;

  // header byte positions
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  localparam logic [7:0] TYPE_RAW     = 8'd2;
  localparam logic [7:0] TYPE_RLE     = 8'd10;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] BPP_32       = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [1:0] BYTE_ALPHA   = 2'd3;

  logic [2:0]  phase_r,     phase_nxt;
  logic [4:0]  hdr_cnt_r,   hdr_cnt_nxt;
  logic [7:0]  id_rem_r,    id_rem_nxt;
  logic        is_rle_r,    is_rle_nxt;
  logic        has_alpha_r, has_alpha_nxt;
  logic [15:0] width_r,     width_nxt;
  logic [15:0] height_r,    height_nxt;
  logic        top_r,       top_nxt;
  logic [23:0] pix_r,       pix_nxt;
  logic [1:0]  bip_r,       bip_nxt;
  logic [7:0]  pkt_rem_r,   pkt_rem_nxt;
  logic        pkt_rep_r,   pkt_rep_nxt;
  logic [31:0] done_r,      done_nxt;
  logic [31:0] left_r,      left_nxt;
  logic [2:0]  err_r,       err_nxt;

  logic [7:0]  b;
  logic [23:0] pix_g;
  logic        g_done;
  logic [7:0]  alpha_g;
  logic [31:0] area;
  logic        run_v;
  logic [7:0]  run_len;
  logic [2:0]  status;
  logic [7:0]  rle_len;

  assign b    = in_data.byte_value;
  assign area = {16'b0, width_r} * {16'b0, height_r};

  // pixel byte gathering, stored as B,G,R from low to high
  always_comb begin
    pix_g   = pix_r;
    g_done  = 1'b0;
    alpha_g = ALPHA_OPAQUE;
    case (bip_r)
      2'd0: pix_g[7:0]   = b;
      2'd1: pix_g[15:8]  = b;
      2'd2: begin
        pix_g[23:16] = b;
        g_done       = !has_alpha_r;
      end
      default: begin
        alpha_g = b;
        g_done  = 1'b1;
      end
    endcase
  end

  // run length of a repeat packet, clipped to the pixels that remain
  assign rle_len = ({24'b0, pkt_rem_r} < left_r) ? pkt_rem_r : left_r[7:0];

  // next state per accepted byte
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    id_rem_nxt    = id_rem_r;
    is_rle_nxt    = is_rle_r;
    has_alpha_nxt = has_alpha_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    top_nxt       = top_r;
    pix_nxt       = pix_r;
    bip_nxt       = bip_r;
    pkt_rem_nxt   = pkt_rem_r;
    pkt_rep_nxt   = pkt_rep_r;
    done_nxt      = done_r;
    left_nxt      = left_r;
    err_nxt       = err_r;
    run_v         = 1'b0;
    run_len       = 8'd1;

    unique case (phase_r)
      PH_HEADER: begin
        unique case (hdr_cnt_r)
          HDR_ID_LEN: id_rem_nxt = b;
          HDR_IMG_TYPE: begin
            is_rle_nxt = (b == TYPE_RLE);
            if (b != TYPE_RAW && b != TYPE_RLE) err_nxt = ST_BAD_TYPE;
          end
          HDR_WIDTH_LO:  width_nxt  = {8'b0, b};
          HDR_WIDTH_HI:  width_nxt  = {b, width_r[7:0]};
          HDR_HEIGHT_LO: height_nxt = {8'b0, b};
          HDR_HEIGHT_HI: begin
            height_nxt = {b, height_r[7:0]};
            if (width_r == 16'd0 || height_nxt == 16'd0) err_nxt = ST_ZERO_SIZE;
          end
          HDR_DEPTH: begin
            has_alpha_nxt = (b == BPP_32);
            if (b != BPP_24 && b != BPP_32 && err_r != ST_ZERO_SIZE)
              err_nxt = ST_BAD_DEPTH;
          end
          HDR_DESC: begin
            top_nxt  = b[5];
            left_nxt = area;
            if (err_r != ST_OK)        phase_nxt = PH_DRAIN;
            else if (id_rem_r != 8'd0) phase_nxt = PH_IDSKIP;
            else                       phase_nxt = is_rle_r ? PH_RLEHDR : PH_RAWPIX;
          end
          default: ;
        endcase
        if (hdr_cnt_r < HDR_DESC) hdr_cnt_nxt = hdr_cnt_r + 5'd1;
      end
      PH_IDSKIP: begin
        id_rem_nxt = id_rem_r - 8'd1;
        if (id_rem_nxt == 8'd0) phase_nxt = is_rle_r ? PH_RLEHDR : PH_RAWPIX;
      end
      PH_RAWPIX: begin
        if (g_done) begin
          run_v    = 1'b1;
          run_len  = 8'd1;
          done_nxt = done_r + 32'd1;
          left_nxt = left_r - 32'd1;
          pix_nxt  = 24'd0;
          bip_nxt  = 2'd0;
          if (left_nxt == 32'd0) phase_nxt = PH_DRAIN;
        end else begin
          pix_nxt = pix_g;
          bip_nxt = bip_r + 2'd1;
        end
      end
      PH_RLEHDR: begin
        pkt_rem_nxt = {1'b0, b[6:0]} + 8'd1;
        pkt_rep_nxt = b[7];
        phase_nxt   = PH_RLEPIX;
      end
      PH_RLEPIX: begin
        if (g_done) begin
          run_v = 1'b1;
          if (pkt_rep_r) begin
            run_len     = rle_len;
            pkt_rem_nxt = 8'd0;
          end else begin
            run_len     = 8'd1;
            pkt_rem_nxt = pkt_rem_r - 8'd1;
          end
          done_nxt = done_r + {24'b0, run_len};
          left_nxt = left_r - {24'b0, run_len};
          pix_nxt  = 24'd0;
          bip_nxt  = 2'd0;
          if (left_nxt == 32'd0)         phase_nxt = PH_DRAIN;
          else if (pkt_rem_nxt == 8'd0)  phase_nxt = PH_RLEHDR;
        end else begin
          pix_nxt = pix_g;
          bip_nxt = bip_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // end report status, from the updated state
  always_comb begin
    status = ST_OK;
    if (phase_r == PH_HEADER && hdr_cnt_r < HDR_DESC)      status = ST_SHORT;
    else if (err_nxt != ST_OK)                             status = err_nxt;
    else if (phase_r == PH_HEADER || phase_r == PH_IDSKIP) status = ST_NO_PIXELS;
    else if (!is_rle_nxt && left_nxt != 32'd0)             status = ST_RAW_TRUNC;
  end

  // work record
  always_comb begin
    rec.has_run      = run_v;
    rec.has_rep      = in_data.last_byte;
    rec.red          = pix_g[23:16];
    rec.green        = pix_g[15:8];
    rec.blue         = pix_g[7:0];
    rec.alpha        = (bip_r == BYTE_ALPHA) ? alpha_g : ALPHA_OPAQUE;
    rec.run_len      = run_len;
    rec.run_start    = done_r;
    rec.rep_status   = status;
    rec.rep_start    = done_nxt;
    rec.top_origin   = top_nxt;
    rec.image_width  = width_nxt;
    rec.image_height = height_nxt;
  end

  assign push = accept && (run_v || in_data.last_byte);

  // state registers; the last byte returns the parser to its reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.last_byte)) begin
      phase_r     <= PH_HEADER;
      hdr_cnt_r   <= 5'd0;
      id_rem_r    <= 8'd0;
      is_rle_r    <= 1'b0;
      has_alpha_r <= 1'b0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      top_r       <= 1'b0;
      pix_r       <= 24'd0;
      bip_r       <= 2'd0;
      pkt_rem_r   <= 8'd0;
      pkt_rep_r   <= 1'b0;
      done_r      <= 32'd0;
      left_r      <= 32'd0;
      err_r       <= ST_OK;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      id_rem_r    <= id_rem_nxt;
      is_rle_r    <= is_rle_nxt;
      has_alpha_r <= has_alpha_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      top_r       <= top_nxt;
      pix_r       <= pix_nxt;
      bip_r       <= bip_nxt;
      pkt_rem_r   <= pkt_rem_nxt;
      pkt_rep_r   <= pkt_rep_nxt;
      done_r      <= done_nxt;
      left_r      <= left_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

`default_nettype wire

[design/tga_rle_queue.sv]
// ============================================================================
// tga_rle_queue
// Small register queue of work records between the parser and the emitter.
// ============================================================================
`default_nettype none

module tga_rle_queue #(
  parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire tga_rle_pkg::tga_rle_rec_t push_data,
  output logic                           full,
  input  wire logic                      pop,
  output tga_rle_pkg::tga_rle_rec_t      head,
  output logic                           head_valid
);
  import tga_rle_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tga_rle_rec_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

[design/tga_rle_back.sv]
// ============================================================================
// tga_rle_back
// Emitter: turns queued work records into result transactions, run first and
// end report second, through a registered output stage.
// ============================================================================
`default_nettype none

module tga_rle_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tga_rle_pkg::tga_rle_rec_t head,
  input  wire logic                      head_valid,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tga_rle_pkg::tga_rle_out_t      out_data
);
  import tga_rle_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  logic         sel_r,       sel_nxt;
  tga_rle_out_t out_data_r;
  tga_rle_out_t item;
  logic         take;
  logic         first;
  logic         rec_end;

  assign take    = head_valid && (!out_valid_r || out_ready);
  assign first   = head.has_run && !sel_r;
  assign rec_end = !first || !head.has_rep;
  assign pop     = take && rec_end;

  // pick the run or the report out of the head record
  always_comb begin
    item.top_origin   = head.top_origin;
    item.image_width  = head.image_width;
    item.image_height = head.image_height;
    if (first) begin
      item.kind        = KIND_RUN;
      item.status      = ST_OK;
      item.red         = head.red;
      item.green       = head.green;
      item.blue        = head.blue;
      item.alpha       = head.alpha;
      item.run_length  = head.run_len;
      item.start_index = head.run_start;
    end else begin
      item.kind        = (head.rep_status != ST_OK) ? KIND_REJECT : KIND_DONE;
      item.status      = head.rep_status;
      item.red         = 8'd0;
      item.green       = 8'd0;
      item.blue        = 8'd0;
      item.alpha       = 8'd0;
      item.run_length  = 8'd0;
      item.start_index = head.rep_start;
    end
  end

  // output stage control
  always_comb begin
    out_valid_nxt = out_valid_r;
    sel_nxt       = sel_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      sel_nxt       = !rec_end;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/tga_truecolor_rle_decoder.sv]
// ============================================================================
// tga_truecolor_rle_decoder
// Streaming TGA decoder for raw and RLE truecolor files, 24 or 32 bpp, that
// delivers RGBA pixel runs and one end report per file.
// ============================================================================
//
// channel   direction  handshake              payload
// in_*      input      in_valid / in_ready    tga_rle_in_t  (one file byte)
// out_*     output     out_valid / out_ready  tga_rle_out_t (run or report)
//
// One byte is accepted per cycle while the record queue has room.
// An accepted byte's record passes through the queue register and then the
// output register. A byte that ends a run and the file yields two results,
// a run and then a report; the QUEUE_DEPTH record queue absorbs that.
// Synchronous active-low reset clears parser, queue and output valid.
// Either side may stall; the queue lets the parser and the emitter wait apart.
//
`default_nettype none

module tga_truecolor_rle_decoder #(
  parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire tga_rle_pkg::tga_rle_in_t  in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tga_rle_pkg::tga_rle_out_t      out_data
);
  import tga_rle_pkg::*;

  tga_rle_rec_t rec;
  tga_rle_rec_t head;
  logic         push;
  logic         full;
  logic         pop;
  logic         head_valid;
  logic         accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // byte parser
  tga_rle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .accept  (accept),
    .rec     (rec),
    .push    (push)
  );

  // record queue
  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (rec),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // result emitter
  tga_rle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // records are only built from accepted bytes
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("record pushed without an accepted byte");

  // every pushed record carries at least one result
  a_rec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (rec.has_run || rec.has_rep))
    else $error("empty record pushed");

  // run lengths stay within one RLE packet
  a_run_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (push && rec.has_run) |-> (rec.run_len != 8'd0 && rec.run_len <= 8'd128))
    else $error("run length out of range");

  // a popped record leaves its last result in the output register
  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("record popped without a result on the output");

endmodule

`default_nettype wire
